>>> design/twu_pkg.sv
package twu_pkg;

  localparam logic [7:0] FEND     = 8'hC0;
  localparam logic [7:0] FESC     = 8'hDB;
  localparam logic [7:0] FESC_END = 8'hDC;
  localparam logic [7:0] FESC_ESC = 8'hDD;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int LEN_W = 12;

  // configuration register indexes
  localparam logic [1:0] CFG_PACKET_TYPE   = 2'd0;
  localparam logic [1:0] CFG_RELIABLE_FLAG = 2'd1;
  localparam logic [1:0] CFG_SEQUENCE_SEED = 2'd2;

  // input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // work entry passed from the front end to the byte engine
  typedef struct packed {
    logic            start;  // header entry: SOF plus four header bytes
    logic            close;  // append crc and EOF after the body
    logic [3:0][7:0] bytes;  // header bytes, or the data byte in slot 0
  } twu_entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> design/twu_front.sv
module twu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 cmd,
  input  logic [11:0]          frame_length,
  input  logic [7:0]           data_byte,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [3:0]           cfg_data,
  output logic                 q_push,
  output twu_pkg::twu_entry_t  q_entry
);
  import twu_pkg::*;

  logic [3:0]       type_r, type_nxt;
  logic             rel_r, rel_nxt;
  logic [2:0]       seq_r, seq_nxt;
  logic             open_r, open_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;

  logic [2:0]       seq_inc;
  logic [2:0]       ack_val;
  logic [7:0]       h0, h1, h2, h3;
  logic [LEN_W-1:0] remain_dec;

  assign seq_inc    = seq_r + 3'd1;
  assign ack_val    = seq_inc + 3'd1;
  assign h0         = {rel_r, 1'b1, ack_val, seq_inc};
  assign h1         = {frame_length[3:0], type_r};
  assign h2         = frame_length[11:4];
  assign h3         = 8'(8'd0 - 8'(h0 + h1 + h2));
  assign remain_dec = remain_r - LEN_W'(1);

  always_comb begin
    type_nxt   = type_r;
    rel_nxt    = rel_r;
    seq_nxt    = seq_r;
    open_nxt   = open_r;
    remain_nxt = remain_r;
    q_push     = 1'b0;
    q_entry    = '0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PACKET_TYPE:   type_nxt = cfg_data;
        CFG_RELIABLE_FLAG: rel_nxt  = cfg_data[0];
        CFG_SEQUENCE_SEED: seq_nxt  = cfg_data[2:0];
        default: ;
      endcase
    end
    if (accept) begin
      if (cmd == CMD_START) begin
        seq_nxt       = seq_inc;
        remain_nxt    = frame_length;
        open_nxt      = (frame_length != '0);
        q_push        = 1'b1;
        q_entry.start = 1'b1;
        q_entry.close = (frame_length == '0);
        q_entry.bytes = {h3, h2, h1, h0};
      end else if (open_r) begin
        remain_nxt       = remain_dec;
        open_nxt         = (remain_dec != '0);
        q_push           = 1'b1;
        q_entry.start    = 1'b0;
        q_entry.close    = (remain_dec == '0);
        q_entry.bytes[0] = data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r   <= 4'd14;
      rel_r    <= 1'b1;
      seq_r    <= '0;
      open_r   <= 1'b0;
      remain_r <= '0;
    end else begin
      type_r   <= type_nxt;
      rel_r    <= rel_nxt;
      seq_r    <= seq_nxt;
      open_r   <= open_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

>>> design/twu_fifo.sv
module twu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  twu_pkg::twu_entry_t  din,
  input  logic                 pop,
  output twu_pkg::twu_entry_t  dout,
  output logic                 full,
  output logic                 nempty
);
  import twu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  twu_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign nempty  = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && nempty;
  assign dout    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> design/twu_back.sv
module twu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_nempty,
  input  twu_pkg::twu_entry_t  q_entry,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 out_run_last,
  output logic                 out_frame_end
);
  import twu_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SOF    = 6'b000010,
    PH_BODY   = 6'b000100,
    PH_CRC_LO = 6'b001000,
    PH_CRC_HI = 6'b010000,
    PH_EOF    = 6'b100000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  twu_entry_t cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] esc2_r, esc2_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       fend_r, fend_nxt;

  logic [7:0] tok_byte;
  logic       tok_esc, tok_crc;
  logic       need_esc, tok_done, body_last, entry_final;
  logic       step, emit, load;
  logic [7:0] emit_byte;

  assign empty         = !vld_r;
  assign out_byte      = byte_r;
  assign out_run_last  = last_r;
  assign out_frame_end = fend_r;

  always_comb begin
    tok_byte = FEND;
    tok_esc  = 1'b0;
    tok_crc  = 1'b0;
    unique case (phase_r)
      PH_BODY: begin
        tok_byte = cur_r.bytes[idx_r];
        tok_esc  = 1'b1;
        tok_crc  = 1'b1;
      end
      PH_CRC_LO: begin
        tok_byte = crc_r[7:0];
        tok_esc  = 1'b1;
      end
      PH_CRC_HI: begin
        tok_byte = crc_r[15:8];
        tok_esc  = 1'b1;
      end
      PH_IDLE, PH_SOF, PH_EOF: tok_byte = FEND;
      default: tok_byte = FEND;
    endcase
  end

  assign need_esc    = tok_esc && (tok_byte == FEND || tok_byte == FESC);
  assign tok_done    = esc_r || !need_esc;
  assign emit_byte   = esc_r ? esc2_r : (need_esc ? FESC : tok_byte);
  assign body_last   = (idx_r == (cur_r.start ? 2'd3 : 2'd0));
  assign entry_final = (phase_r == PH_EOF) ||
                       (phase_r == PH_BODY && body_last && !cur_r.close);
  assign step        = !vld_r || pop;
  assign emit        = step && (phase_r != PH_IDLE);
  assign load        = q_nempty &&
                       ((phase_r == PH_IDLE) || (emit && tok_done && entry_final));
  assign q_pop       = load;

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    esc_nxt   = esc_r;
    esc2_nxt  = esc2_r;
    vld_nxt   = vld_r && !pop;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    fend_nxt  = fend_r;
    if (emit) begin
      vld_nxt  = 1'b1;
      byte_nxt = emit_byte;
      last_nxt = tok_done && entry_final;
      fend_nxt = (phase_r == PH_EOF);
      esc_nxt  = !esc_r && need_esc;
      esc2_nxt = (tok_byte == FEND) ? FESC_END : FESC_ESC;
      if (!esc_r && tok_crc) begin
        crc_nxt = crc_byte(crc_r, tok_byte);
      end
      if (tok_done) begin
        unique case (phase_r)
          PH_SOF: begin
            phase_nxt = PH_BODY;
            idx_nxt   = '0;
          end
          PH_BODY: begin
            if (!body_last) begin
              idx_nxt = idx_r + 2'd1;
            end else if (cur_r.close) begin
              phase_nxt = PH_CRC_LO;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_CRC_LO: phase_nxt = PH_CRC_HI;
          PH_CRC_HI: phase_nxt = PH_EOF;
          PH_EOF:    phase_nxt = PH_IDLE;
          default:   phase_nxt = PH_IDLE;
        endcase
      end
    end
    // next entry takes over as soon as the current one hands out its last byte
    if (load) begin
      cur_nxt   = q_entry;
      idx_nxt   = '0;
      phase_nxt = q_entry.start ? PH_SOF : PH_BODY;
      if (q_entry.start) begin
        crc_nxt = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    esc2_r <= esc2_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    fend_r <= fend_nxt;
    idx_r  <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      crc_r   <= CRC_INIT;
      esc_r   <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      esc_r   <= esc_nxt;
      vld_r   <= vld_nxt;
    end
  end

endmodule

>>> design/three_wire_uart_slip_packet_framer.sv
// three-wire uart packet framer with slip byte stuffing
//
// input queue port: an item is taken on a clock edge with push high and full low.
//   cmd 0 opens a frame of frame_length payload bytes: the sequence number advances
//   and 0xC0 plus the four header bytes go out (plus crc and closing 0xC0 when the
//   length is zero). cmd 1 carries one payload byte; the last one is followed by
//   the crc16 (low byte first) and the closing 0xC0. a payload item with no frame
//   open is taken and dropped. 0xC0 and 0xDB inside a frame go out as DB DC / DB DD
// result queue port: the oldest byte sits on out_byte while empty is low and is
//   taken on an edge with pop high. out_run_last flags the final byte of an item,
//   out_frame_end flags the closing delimiter
// config: cfg_we writes cfg_data into register cfg_index (type, reliable, seed)
// path: with the byte engine idle, an item is written into the entry queue, loaded
//   into the byte engine, and its first byte is then registered onto out_byte
// throughput: while the receiver keeps popping, the byte engine hands out one byte per
//   cycle; an item produces no bytes when it is a dropped payload item and up to
//   fourteen otherwise; the entry queue lets the input side run ahead by FIFO_DEPTH items
// reset (synchronous, rst_n low) clears both queues, the sequence number and the
//   open frame, and loads the register defaults
// when the receiver stalls the output byte holds, the engine waits, and full rises
//   once the entry queue fills
module three_wire_uart_slip_packet_framer #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic        in_cmd,
  input  logic [11:0] in_frame_length,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_frame_end,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import twu_pkg::*;

  logic       accept;
  logic       q_push, q_pop, q_nempty;
  twu_entry_t q_din, q_dout;

  assign accept = push && !full;

  // front end: tracks frame state and turns items into work entries
  twu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cmd          (in_cmd),
    .frame_length (in_frame_length),
    .data_byte    (in_data_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_push       (q_push),
    .q_entry      (q_din)
  );

  // decoupling queue between the two halves
  twu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .din    (q_din),
    .pop    (q_pop),
    .dout   (q_dout),
    .full   (full),
    .nempty (q_nempty)
  );

  // byte engine: delimiters, crc, escaping, output register
  twu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_nempty      (q_nempty),
    .q_entry       (q_dout),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

>>> design/twu_checker.sv
module twu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_frame_end
);
  import twu_pkg::*;

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // closing delimiter is always 0xC0 and ends its item
  a_eof_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> (out_byte == FEND && out_run_last))
    else $error("frame end flag on a wrong byte");

  // an escape lead byte is never the last byte of an item
  a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_byte == FESC) |-> (!out_run_last && !out_frame_end))
    else $error("escape lead byte closes an item");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte)))
    else $error("stalled result changed");

endmodule

bind three_wire_uart_slip_packet_framer twu_checker u_twu_checker (.*);

>>> tb/tb_three_wire_uart_slip_packet_framer.sv
`timescale 1ns / 1ps

module tb_three_wire_uart_slip_packet_framer;
  import twu_pkg::*;

  // cycles with work outstanding but no handshake on either side
  localparam int STALL_LIMIT = 5000;
  // settle time after the last byte, covers items that make no bytes
  localparam int SETTLE_CYCLES = 16;
  localparam int CHUNK_ITEMS = 65;

  typedef struct {
    logic        cmd;
    logic [11:0] len;
    logic [7:0]  payload;
  } frame_item_t;

  typedef struct {
    logic [7:0] value;
    logic       is_last;
    logic       ends_frame;
  } line_byte_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_cmd;
  logic [11:0] in_frame_length;
  logic [7:0]  in_data_byte;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_frame_end;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  three_wire_uart_slip_packet_framer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_cmd          (in_cmd),
    .in_frame_length (in_frame_length),
    .in_data_byte    (in_data_byte),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_frame_end   (out_frame_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // items waiting to be pushed, and the line bytes the framer owes us
  frame_item_t items_to_send[$];
  line_byte_t  line_expected[$];

  // predictor copy of the framer registers and state
  logic [3:0]  cur_type;
  logic        cur_reliable;
  logic [2:0]  seq_ctr;
  logic [15:0] crc_acc;
  logic [11:0] left_count;
  logic        in_frame;

  // idle percentages for each side
  int send_idle_pct;
  int recv_idle_pct;

  // stimulus side view of the open frame: payload items still owed
  int gen_left;

  int fail_count;
  int items_taken;
  int bytes_checked;
  int frames_closed;
  int escapes_seen;
  int settings_used;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // crc16, polynomial 0x1021, msb first, one data bit per step
  function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] acc,
                                                   input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  task automatic put_line(input logic [7:0] v, input logic fe);
    line_byte_t e;
    e.value = v;
    e.is_last = 1'b0;
    e.ends_frame = fe;
    line_expected.push_back(e);
  endtask

  // slip stuffing of one byte between the delimiters
  task automatic put_stuffed(input logic [7:0] v);
    if (v == FEND) begin
      put_line(FESC, 1'b0);
      put_line(FESC_END, 1'b0);
    end else if (v == FESC) begin
      put_line(FESC, 1'b0);
      put_line(FESC_ESC, 1'b0);
    end else begin
      put_line(v, 1'b0);
    end
  endtask

  // header and payload bytes go through the crc before stuffing
  task automatic put_framed(input logic [7:0] v);
    crc_acc = crc16_ccitt_step(crc_acc, v);
    put_stuffed(v);
  endtask

  // crc low byte first, then the closing delimiter
  task automatic put_trailer();
    logic [15:0] c;
    c = crc_acc;
    put_stuffed(c[7:0]);
    put_stuffed(c[15:8]);
    put_line(FEND, 1'b1);
    in_frame = 1'b0;
    left_count = '0;
  endtask

  // line bytes caused by one accepted item
  task automatic encode_item(input frame_item_t it);
    int first;
    logic [7:0] h0, h1, h2, h3;
    first = line_expected.size();
    if (it.cmd == CMD_START) begin
      // a start drops whatever frame was open, no crc and no closing delimiter
      seq_ctr = seq_ctr + 3'd1;
      h0 = {cur_reliable, 1'b1, 3'(seq_ctr + 3'd1), seq_ctr};
      h1 = {it.len[3:0], cur_type};
      h2 = it.len[11:4];
      h3 = 8'd0 - (h0 + h1 + h2);
      crc_acc = CRC_INIT;
      in_frame = 1'b1;
      left_count = it.len;
      put_line(FEND, 1'b0);
      put_framed(h0);
      put_framed(h1);
      put_framed(h2);
      put_framed(h3);
      // zero length: whole frame comes out at once
      if (left_count == '0) put_trailer();
    end else if (in_frame) begin
      put_framed(it.payload);
      left_count = left_count - 12'd1;
      if (left_count == '0) put_trailer();
    end
    // payload with no frame open makes nothing
    if (line_expected.size() > first) line_expected[line_expected.size() - 1].is_last = 1'b1;
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (items_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        in_cmd <= items_to_send[0].cmd;
        in_frame_length <= items_to_send[0].len;
        in_data_byte <= items_to_send[0].payload;
      end else begin
        push <= 1'b0;
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: both handshakes sampled on the rising edge
  always @(posedge clk) begin : monitor
    line_byte_t want;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (pop && empty === 1'b0) begin
        moved = 1'b1;
        if (line_expected.size() == 0) begin
          $error("unexpected byte %02h on the line", out_byte);
          fail_count++;
        end else begin
          want = line_expected.pop_front();
          bytes_checked++;
          if (want.ends_frame) frames_closed++;
          if (want.value == FESC) escapes_seen++;
          if (out_byte !== want.value) begin
            $error("out_byte: expected %02h, got %02h", want.value, out_byte);
            fail_count++;
          end
          if (out_run_last !== want.is_last) begin
            $error("out_run_last: expected %0b, got %0b", want.is_last, out_run_last);
            fail_count++;
          end
          if (out_frame_end !== want.ends_frame) begin
            $error("out_frame_end: expected %0b, got %0b", want.ends_frame, out_frame_end);
            fail_count++;
          end
        end
      end
      if (push && full === 1'b0) begin
        moved = 1'b1;
        encode_item(items_to_send.pop_front());
        items_taken++;
      end
      // watchdog only runs while something is outstanding
      if (!moved && (items_to_send.size() > 0 || line_expected.size() > 0))
        stall_cycles++;
      else
        stall_cycles = 0;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic add_item(input logic cmd, input logic [11:0] len, input logic [7:0] b);
    frame_item_t it;
    it.cmd = cmd;
    it.len = len;
    it.payload = b;
    items_to_send.push_back(it);
  endtask

  // register write; the framer is idle here so the predictor follows at once
  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PACKET_TYPE:   cur_type = val;
      CFG_RELIABLE_FLAG: cur_reliable = val[0];
      CFG_SEQUENCE_SEED: seq_ctr = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [3:0] t, input logic r, input logic [2:0] s);
    write_reg(CFG_PACKET_TYPE, t);
    write_reg(CFG_RELIABLE_FLAG, {3'b000, r});
    write_reg(CFG_SEQUENCE_SEED, {1'b0, s});
    settings_used++;
  endtask

  // sender holds off until every owed byte is out, then lets the pipe settle
  task automatic wait_drained();
    while (items_to_send.size() > 0 || line_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly short frames, a few longer ones
  function automatic int short_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(4);
    else if (r < 90) return $urandom_range(16, 5);
    else return $urandom_range(40, 17);
  endfunction

  // payload biased toward the bytes that need stuffing
  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(7);
    if (r == 0) return FEND;
    else if (r == 1) return FESC;
    else return 8'($urandom_range(255));
  endfunction

  // random traffic: whole frames, frames cut off by the next start, stray payload
  task automatic gen_chunk(input int target);
    int made, pick, len, k, cut;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = short_length();
        add_item(CMD_START, 12'(len), 8'($urandom));
        made++;
        for (k = 0; k < len; k++) begin
          add_item(CMD_DATA, 12'($urandom), payload_byte());
          made++;
        end
        gen_left = 0;
      end else if (pick < 85) begin
        // leave the frame open; a later start drops it
        k = $urandom_range(99);
        if (k < 20) len = 4095;
        else if (k < 45) len = $urandom_range(4095, 2);
        else len = short_length() + 2;
        cut = $urandom_range((len - 1 < 8) ? len - 1 : 8);
        add_item(CMD_START, 12'(len), 8'($urandom));
        made++;
        for (k = 0; k < cut; k++) begin
          add_item(CMD_DATA, 12'($urandom), payload_byte());
          made++;
        end
        gen_left = len - cut;
      end else begin
        // stray payload, either continuing an open frame or ignored
        add_item(CMD_DATA, 12'($urandom), payload_byte());
        if (gen_left > 0) begin
          made++;
          gen_left--;
        end
      end
    end
  endtask

  initial begin
    // all inputs known from time zero, register defaults in the predictor
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_cmd = CMD_START;
    in_frame_length = '0;
    in_data_byte = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PACKET_TYPE;
    cfg_data = '0;
    cur_type = 4'd14;
    cur_reliable = 1'b1;
    seq_ctr = '0;
    crc_acc = CRC_INIT;
    left_count = '0;
    in_frame = 1'b0;
    gen_left = 0;
    fail_count = 0;
    items_taken = 0;
    bytes_checked = 0;
    frames_closed = 0;
    escapes_seen = 0;
    settings_used = 1;
    stall_cycles = 0;
    send_idle_pct = 24;
    recv_idle_pct = 77;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset register values
    // payload before any frame is dropped
    add_item(CMD_DATA, 12'h000, 8'hFF);
    // zero-length frame
    add_item(CMD_START, 12'h000, 8'h00);
    // longest length, left open after two bytes
    add_item(CMD_START, 12'hFFF, 8'hFF);
    add_item(CMD_DATA, 12'hFFF, 8'h00);
    add_item(CMD_DATA, 12'h000, 8'hFF);
    // start on an open frame, payload with both escape bytes
    add_item(CMD_START, 12'h003, 8'h5A);
    add_item(CMD_DATA, 12'h000, FEND);
    add_item(CMD_DATA, 12'h000, FESC);
    add_item(CMD_DATA, 12'h000, 8'h7E);
    // stray payload after a closed frame
    add_item(CMD_DATA, 12'h000, 8'h55);
    // one-byte frame
    add_item(CMD_START, 12'h001, 8'h00);
    add_item(CMD_DATA, 12'h000, 8'h00);
    // header length bytes that need stuffing, then a frame with both escape bytes
    add_item(CMD_START, 12'hC00, 8'h00);
    add_item(CMD_START, 12'hDB0, 8'h00);
    add_item(CMD_START, 12'h002, 8'h00);
    add_item(CMD_DATA, 12'h000, FESC);
    add_item(CMD_DATA, 12'h000, FEND);
    // frame left open so the seed write lands mid-frame
    add_item(CMD_START, 12'h5A5, 8'h00);
    add_item(CMD_DATA, 12'h000, 8'h12);
    gen_left = 12'h5A4;
    wait_drained();

    // random part in chunks, new settings before each
    for (int c = 0; c < 6; c++) begin
      if (c == 2) begin
        send_idle_pct = 77;
        recv_idle_pct = 24;
      end else if (c == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (c)
        0: apply_settings(4'd0, 1'b0, 3'd7);
        1: apply_settings(4'd15, 1'b1, 3'd0);
        2: apply_settings(4'd11, 1'($urandom), 3'($urandom));
        default: apply_settings(4'($urandom), 1'($urandom), 3'($urandom));
      endcase
      gen_chunk(CHUNK_ITEMS);
      wait_drained();
    end

    $display("framer run: %0d items, %0d line bytes checked, %0d frames closed",
             items_taken, bytes_checked, frames_closed);
    $display("%0d register settings, %0d escape bytes, three idle profiles",
             settings_used, escapes_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
